// ----- hw/rtl/rhc_pkg.sv -----
package rhc_pkg;

  // Width of one color component and of the hue and saturation fractions.
  localparam int COMPONENT_BITS = 8;
  localparam int FRACTION_BITS  = 16;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0]  hue;
    logic [FRACTION_BITS-1:0]  saturation;
    logic [COMPONENT_BITS-1:0] brightness;
    logic                      hue_undefined;
  } hsv_t;

endpackage

// ----- hw/rtl/rgb_to_hsv_convert.sv -----
// Throughput: one pixel per clock cycle while hsv_ready is high; each stage holds one pixel, and a stall
// anywhere downstream only holds the stages that are occupied.
// Reset (rst, synchronous, active high) clears the valid bit of every stage; the
// data registers are not reset.
module rgb_to_hsv_convert
  import rhc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_ready,
  output hsv_t   hsv
);

  localparam int C = COMPONENT_BITS;
  localparam int F = FRACTION_BITS;
  // Six times delta is below 6 * 2^C, so three extra bits hold it.
  localparam int SB = C + 3;
  // One preprocessing stage, then one stage per quotient bit. Saturation needs
  // F + 1 quotient bits because the quotient can reach exactly one full unit.
  localparam int STAGES = F + 2;

  // Everything one pixel carries through the pipeline. Both divisions run in
  // lockstep, so a single record per stage is enough.
  typedef struct packed {
    logic [C-1:0]  brightness;
    logic          undef;
    logic [C-1:0]  sat_rem;
    logic [F:0]    sat_quo;
    logic [C-1:0]  div_max;
    logic [SB-1:0] hue_rem;
    logic [F-1:0]  hue_quo;
    logic [SB-1:0] six;
  } stage_t;

  stage_t st [STAGES];
  logic [STAGES-1:0] vld;
  // adv[k] is high when stage k may load this cycle: it is empty, or the stage
  // after it moves on as well. The last entry is the consumer's ready.
  logic [STAGES:0] adv;

  assign adv[STAGES] = hsv_ready;

  genvar k;
  generate
    for (k = 0; k < STAGES; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end
  endgenerate

  assign pixel_ready = adv[0];

  // ---------------------------------------------------------------------------
  // Stage 0: find max and min, delta, six times delta, and the hue numerator
  // already reduced into the range [0, 6 * delta).
  // ---------------------------------------------------------------------------
  logic [C-1:0]  mx, mn, delta, delta_nz;
  logic [SB-1:0] dnz_w, six_w, r_w, g_w, b_w, x_w;
  stage_t        pre;

  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;

    delta = mx - mn;
    // A gray pixel divides by one instead of zero; its hue numerator is zero.
    delta_nz = (delta == '0) ? C'(1) : delta;

    dnz_w = SB'(delta_nz);
    six_w = (dnz_w << 2) + (dnz_w << 1);
    r_w   = SB'(pixel.red);
    g_w   = SB'(pixel.green);
    b_w   = SB'(pixel.blue);

    // Red wins ties, then green. Only the red sector can fall below zero, and
    // then one turn of six times delta brings it back into range. The other
    // sectors stay within [delta, 5 * delta], so modular arithmetic is exact.
    priority if (pixel.red == mx) begin
      if (pixel.green >= pixel.blue) begin
        x_w = g_w - b_w;
      end else begin
        x_w = six_w - (b_w - g_w);
      end
    end else if (pixel.green == mx) begin
      x_w = (dnz_w << 1) + b_w - r_w;
    end else begin
      x_w = (dnz_w << 2) + r_w - g_w;
    end

    pre.brightness = mx;
    pre.undef      = (mx == '0);
    pre.sat_rem    = delta;
    pre.sat_quo    = '0;
    pre.div_max    = mx;
    pre.hue_rem    = x_w;
    pre.hue_quo    = '0;
    pre.six        = six_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0] <= pre;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1 to F + 1: restoring division, one quotient bit per stage.
  // Saturation divides delta by max; its first stage only compares, since
  // delta never exceeds max. Hue divides x by six times delta and starts one
  // stage later, as x is always below the divisor.
  // ---------------------------------------------------------------------------
  generate
    for (k = 1; k < STAGES; k++) begin : g_div
      localparam int BIT = F + 1 - k;
      localparam bit FIRST = (k == 1);
      // The hue quotient has no bit in the first stage; keep the index in range.
      localparam int HBIT = FIRST ? 0 : BIT;

      stage_t        cur, nxt;
      logic [C:0]    sat_trial;
      logic [SB:0]   hue_trial;

      assign cur = st[k-1];

      always_comb begin
        nxt = cur;

        sat_trial = FIRST ? {1'b0, cur.sat_rem} : {cur.sat_rem, 1'b0};
        if (sat_trial >= {1'b0, cur.div_max}) begin
          nxt.sat_quo[BIT] = 1'b1;
          nxt.sat_rem      = C'(sat_trial - {1'b0, cur.div_max});
        end else begin
          nxt.sat_rem      = C'(sat_trial);
        end

        hue_trial = {cur.hue_rem, 1'b0};
        if (!FIRST) begin
          if (hue_trial >= {1'b0, cur.six}) begin
            nxt.hue_quo[HBIT] = 1'b1;
            nxt.hue_rem       = SB'(hue_trial - {1'b0, cur.six});
          end else begin
            nxt.hue_rem       = SB'(hue_trial);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k]) begin
          st[k] <= nxt;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Result. A pure color gives a saturation quotient of exactly one unit,
  // which clips to the largest code. A black pixel reports zero saturation and
  // zero hue with the undefined flag set.
  // ---------------------------------------------------------------------------
  stage_t last;
  assign last = st[STAGES-1];

  assign hsv_valid = vld[STAGES-1];

  always_comb begin
    hsv.brightness    = last.brightness;
    hsv.hue_undefined = last.undef;
    if (last.undef) begin
      hsv.hue        = '0;
      hsv.saturation = '0;
    end else begin
      hsv.hue        = last.hue_quo;
      hsv.saturation = last.sat_quo[F] ? '1 : last.sat_quo[F-1:0];
    end
  end

endmodule
